### sv/signed_int_to_decimal_ascii_macros.svh
// Assertion macros shared by the signed integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define SIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sida_pkg.sv
// Shared constants and types for the signed integer to decimal text block.
`default_nettype none
package sida_pkg;

  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_ZERO  = 7'd48;

  // Magnitude bits consumed by one conversion stage.
  localparam int STAGE_BITS = 8;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

endpackage
`default_nettype wire

### sv/sida_dabble.sv
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
`default_nettype none
module sida_dabble #(
  parameter int ND = 10,
  parameter int MW = 32,
  parameter int NB = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic                leave,
  input  wire sida_pkg::ctl_t      ctl_i,
  input  wire logic [4*ND-1:0]     bcd_i,
  input  wire logic [MW-1:0]       bin_i,
  output sida_pkg::ctl_t           ctl_o,
  output logic [4*ND-1:0]          bcd_o,
  output logic [MW-1:0]            bin_o
);

  sida_pkg::ctl_t     ctl_r;
  logic [4*ND-1:0]    bcd_r;
  logic [4*ND-1:0]    bcd_nxt;
  logic [MW-1:0]      bin_r;
  logic [MW-1:0]      bin_nxt;

  // Shift NB magnitude bits into the BCD word, adjusting digits before each shift.
  always_comb begin
    bcd_nxt = bcd_i;
    bin_nxt = bin_i;
    for (int j = 0; j < NB; j++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_nxt[4*d +: 4] >= 4'd5) begin
          bcd_nxt[4*d +: 4] = bcd_nxt[4*d +: 4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[4*ND-2:0], bin_nxt[MW-1]};
      bin_nxt = {bin_nxt[MW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (take) begin
      ctl_r <= ctl_i;
    end else if (leave) begin
      ctl_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bcd_r <= bcd_nxt;
      bin_r <= bin_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign bcd_o = bcd_r;
  assign bin_o = bin_r;

endmodule
`default_nettype wire

### sv/signed_int_to_decimal_ascii.sv
// A word accepted on start passes the input register, one BCD stage per 8 magnitude bits,
// the digit scan register and the emitter register on its way to out_strobe.
// Throughput: one character per cycle; a value lasts as long as its text, one digit per
// character plus the minus sign, and values can follow each other on the output with no gap.
// busy rises only while the pipeline is full behind the character emitter.
// rst_n is synchronous: it empties every stage and the emitter.
`default_nettype none
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  output logic                              out_strobe,
  output logic [6:0]                        out_char_code,
  output logic                              out_last_char
);

  `include "signed_int_to_decimal_ascii_macros.svh"

  localparam int MW = VALUE_BITS;
  localparam int ND = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BW = 4 * ND;
  localparam int IW = $clog2(ND);
  localparam int NS = (VALUE_BITS + sida_pkg::STAGE_BITS - 1) / sida_pkg::STAGE_BITS;
  localparam int LAST_NB = VALUE_BITS - sida_pkg::STAGE_BITS * (NS - 1);

  sida_pkg::ctl_t ctl_q [0:NS];
  logic [BW-1:0]  bcd_q [0:NS];
  logic [MW-1:0]  bin_q [0:NS];
  logic [NS+1:0]  free_w;

  sida_pkg::ctl_t ctl0_r;
  logic [MW-1:0]  mag0_r;
  logic [MW-1:0]  raw_w;
  logic [MW-1:0]  mag_w;
  logic           accept_w;

  sida_pkg::ctl_t lz_ctl_r;
  logic [BW-1:0]  lz_bcd_r;
  logic [IW-1:0]  lz_top_r;
  logic [IW-1:0]  lz_top_nxt;
  logic           lz_take_w;

  logic           em_active_r;
  logic           em_minus_r;
  logic [IW-1:0]  em_idx_r;
  logic [BW-1:0]  em_bcd_r;
  logic           em_last_w;
  logic           em_free_w;
  logic           em_load_w;
  logic [3:0]     em_digit_w;

  // Input stage: sign and magnitude; the most negative value wraps to 2^(VALUE_BITS-1).
  assign raw_w    = $unsigned(in_value);
  assign mag_w    = raw_w[MW-1] ? (~raw_w + {{(MW-1){1'b0}}, 1'b1}) : raw_w;
  assign accept_w = start && !busy;
  assign busy     = !free_w[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (accept_w) begin
      ctl0_r.valid <= 1'b1;
      ctl0_r.neg   <= raw_w[MW-1];
    end else if (ctl0_r.valid && free_w[1]) begin
      ctl0_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_w) begin
      mag0_r <= mag_w;
    end
  end

  assign ctl_q[0] = ctl0_r;
  assign bcd_q[0] = '0;
  assign bin_q[0] = mag0_r;

  // A stage is free when empty or when its word moves on this cycle.
  genvar gi;
  generate
    for (gi = 0; gi <= NS; gi++) begin : g_free
      assign free_w[gi] = !ctl_q[gi].valid || free_w[gi+1];
    end

    for (gi = 1; gi <= NS; gi++) begin : g_stage
      sida_dabble #(
        .ND (ND),
        .MW (MW),
        .NB ((gi < NS) ? sida_pkg::STAGE_BITS : LAST_NB)
      ) u_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (ctl_q[gi-1].valid && free_w[gi]),
        .leave (ctl_q[gi].valid && free_w[gi+1]),
        .ctl_i (ctl_q[gi-1]),
        .bcd_i (bcd_q[gi-1]),
        .bin_i (bin_q[gi-1]),
        .ctl_o (ctl_q[gi]),
        .bcd_o (bcd_q[gi]),
        .bin_o (bin_q[gi])
      );
    end
  endgenerate

  // Digit scan: position of the most significant nonzero digit, zero if none.
  always_comb begin
    lz_top_nxt = '0;
    for (int d = 1; d < ND; d++) begin
      if (bcd_q[NS][4*d +: 4] != 4'd0) begin
        lz_top_nxt = IW'(d);
      end
    end
  end

  assign free_w[NS+1] = !lz_ctl_r.valid || em_free_w;
  assign lz_take_w    = ctl_q[NS].valid && free_w[NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lz_ctl_r <= '0;
    end else if (lz_take_w) begin
      lz_ctl_r <= ctl_q[NS];
    end else if (em_load_w) begin
      lz_ctl_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lz_take_w) begin
      lz_bcd_r <= bcd_q[NS];
      lz_top_r <= lz_top_nxt;
    end
  end

  // Emitter: minus sign first, then digits from the top down; reload on the last one.
  assign em_last_w  = em_active_r && !em_minus_r && (em_idx_r == '0);
  assign em_free_w  = !em_active_r || em_last_w;
  assign em_load_w  = lz_ctl_r.valid && em_free_w;
  assign em_digit_w = em_bcd_r[em_idx_r*4 +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_active_r <= 1'b0;
      em_minus_r  <= 1'b0;
      em_idx_r    <= '0;
    end else if (em_load_w) begin
      em_active_r <= 1'b1;
      em_minus_r  <= lz_ctl_r.neg;
      em_idx_r    <= lz_top_r;
    end else if (em_last_w) begin
      em_active_r <= 1'b0;
    end else if (em_active_r) begin
      if (em_minus_r) begin
        em_minus_r <= 1'b0;
      end else begin
        em_idx_r <= em_idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_load_w) begin
      em_bcd_r <= lz_bcd_r;
    end
  end

  assign out_strobe    = em_active_r;
  assign out_char_code = em_minus_r ? sida_pkg::CHAR_MINUS
                                    : (sida_pkg::CHAR_ZERO + {3'b000, em_digit_w});
  assign out_last_char = em_last_w;

  `SIDA_ASSERT_NEXT(a_accept_fills, accept_w, ctl_q[0].valid, "accepted word not captured")
  `SIDA_ASSERT_NEXT(a_stall_holds, ctl_q[NS].valid && !free_w[NS+1], ctl_q[NS].valid,
                    "stalled word dropped at last stage")
  `SIDA_ASSERT_NEXT(a_minus_then_digit, out_strobe && em_minus_r,
                    out_strobe && !em_minus_r, "minus sign not followed by a digit")
  `SIDA_ASSERT_NEXT(a_idle_after_last, out_strobe && out_last_char && !lz_ctl_r.valid,
                    !out_strobe, "character emitted with no word pending")

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench for the signed integer to decimal text converter, checked against its own predictor.
`timescale 1ns / 100ps
module testbench;

  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_WORDS = 200;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                         busy;
  logic                         out_strobe;
  logic [6:0]                   out_char_code;
  logic                         out_last_char;

  logic signed [VALUE_BITS-1:0] pending_values[$];
  text_char_t                   expected_text[$];
  int                           mismatches = 0;
  int                           gap_left = 0;
  int                           no_gap_run = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Queue the characters of one value, sign first, most significant digit next.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS-1:0] mag;
    logic [6:0]            chars[$];
    text_char_t            tc;
    mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    do begin
      chars.push_front(sida_pkg::CHAR_ZERO + 7'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (raw[VALUE_BITS-1]) chars.push_front(sida_pkg::CHAR_MINUS);
    foreach (chars[i]) begin
      tc.code = chars[i];
      tc.last = (i == chars.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  // Mostly no gap, some short ones, a few long ones; now and then a run with none.
  function automatic int pick_gap();
    int r;
    if (no_gap_run > 0) begin
      no_gap_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      no_gap_run = $urandom_range(5, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: hold start until the word is taken, then wait out its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_value <= '0;
    end else begin
      if (start && !busy) predict_text(in_value);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_values.size() > 0) begin
          start    <= 1'b1;
          in_value <= pending_values.pop_front();
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed character is taken; match it with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe !== 1'b0 && out_strobe !== 1'b1) begin
        report_mismatch("out_strobe unknown");
      end else if (out_strobe) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d", out_char_code));
        end else begin
          if (out_char_code !== expected_text[0].code)
            report_mismatch($sformatf("char_code %0d, expected %0d",
                                      out_char_code, expected_text[0].code));
          if (out_last_char !== expected_text[0].last)
            report_mismatch($sformatf("last_char %0b, expected %0b on char %0d",
                                      out_last_char, expected_text[0].last,
                                      expected_text[0].code));
          void'(expected_text.pop_front());
        end
      end
    end
  end

  initial begin
    logic signed [VALUE_BITS-1:0] word;
    longint unsigned              lo;
    longint unsigned              hi;
    int                           ndig;

    // Directed: zero, single digits, powers of ten, both extremes, bit patterns.
    pending_values.push_back(32'sd0);
    pending_values.push_back(32'sd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sd9);
    pending_values.push_back(-32'sd5);
    pending_values.push_back(32'sd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'sd99);
    pending_values.push_back(32'sd100);
    pending_values.push_back(32'sd999999999);
    pending_values.push_back(-32'sd999999999);
    pending_values.push_back(32'sd1000000000);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'h7fffffff);
    pending_values.push_back(32'h80000000);
    pending_values.push_back(32'h80000001);
    pending_values.push_back(32'h55555555);
    pending_values.push_back(32'haaaaaaaa);
    pending_values.push_back(32'h80000000);
    pending_values.push_back(32'sd0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        word = $urandom();
      end else begin
        // Pick a digit count, then a magnitude of exactly that many digits.
        ndig = $urandom_range(1, 10);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        word = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(0, 1)) word = -word;
      end
      pending_values.push_back(word);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_values.size() > 0 || start || expected_text.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii test passed");
    end else begin
      $display("signed_int_to_decimal_ascii test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d characters outstanding", expected_text.size());
    $display("signed_int_to_decimal_ascii test failed");
    $finish;
  end

endmodule
